### rtl/c3rgb_pkg.sv
package c3rgb_pkg;

   // field widths of the stream words
   localparam int CH_W      = 8;
   localparam int PIX_W     = 3 * CH_W;
   localparam int ROW_OUT_W = 12;
   localparam int COL_OUT_W = 11;
   localparam int CFG_W     = 12;

   // parameter defaults
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAX_ROWS_DEF  = 4096;

   // row_width after reset
   localparam logic [CFG_W-1:0] ROW_WIDTH_RST = CFG_W'(640);

   // output queue sizing
   localparam int OUTQ_DEPTH = 3;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   // one result word
   typedef struct packed {
      logic [CH_W-1:0]      blue;
      logic [CH_W-1:0]      green;
      logic [CH_W-1:0]      red;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] column;
   } rsp_word_type;

endpackage

### rtl/c3rgb_outq.sv
module c3rgb_outq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  c3rgb_pkg::rsp_word_type             push_word,
   output logic                                out_valid,
   input  logic                                out_stall,
   output c3rgb_pkg::rsp_word_type             out_word,
   output logic [c3rgb_pkg::OUTQ_CNT_W-1:0]    count
);

   localparam int PTR_W = c3rgb_pkg::OUTQ_PTR_W;
   localparam int CNT_W = c3rgb_pkg::OUTQ_CNT_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(c3rgb_pkg::OUTQ_DEPTH - 1);

   c3rgb_pkg::rsp_word_type entry_ff [c3rgb_pkg::OUTQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_word  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && !out_stall;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### rtl/conv3x3_rgb_clamped_core.sv
// Channel  Dir  Handshake            Word
// req      in   req_valid/req_stall  pixel blue, green, red, last_pixel flag
// rsp      out  rsp_valid/rsp_stall  filtered blue, green, red, center row, column
// csr      in   csr_valid/csr_ready  row_width (csr_ready is always high)
//
// One pixel per clock while req_stall is low. A pixel taken on req is registered
// into stage 1, where the line store read and filter make its result word, if it
// has one; that word is then registered into the output queue before it shows on rsp.
// Reset is synchronous: counters, window and queue clear, row_width goes to 640.
// Line stores are not cleared. A three-entry output queue absorbs rsp stalls;
// req_stall rises only when that queue plus the word in flight would be full.
module conv3x3_rgb_clamped_core #(
   parameter int MAX_WIDTH = c3rgb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_ROWS  = c3rgb_pkg::MAX_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [c3rgb_pkg::CH_W-1:0]          req_pixel_blue,
   input  logic [c3rgb_pkg::CH_W-1:0]          req_pixel_green,
   input  logic [c3rgb_pkg::CH_W-1:0]          req_pixel_red,
   input  logic                                req_last_pixel,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [c3rgb_pkg::CH_W-1:0]          rsp_out_blue,
   output logic [c3rgb_pkg::CH_W-1:0]          rsp_out_green,
   output logic [c3rgb_pkg::CH_W-1:0]          rsp_out_red,
   output logic [c3rgb_pkg::ROW_OUT_W-1:0]     rsp_out_row,
   output logic [c3rgb_pkg::COL_OUT_W-1:0]     rsp_out_column,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [c3rgb_pkg::CFG_W-1:0]         csr_row_width
);

   localparam int CH_W   = c3rgb_pkg::CH_W;
   localparam int PIX_W  = c3rgb_pkg::PIX_W;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CMP_W  = ((COL_W + 2) > (c3rgb_pkg::CFG_W + 1)) ?
                           (COL_W + 2) : (c3rgb_pkg::CFG_W + 1);
   localparam int LOAD_W = c3rgb_pkg::OUTQ_CNT_W + 1;
   localparam int SUM_W  = CH_W + 3;

   localparam logic [CMP_W-1:0] W_MIN    = CMP_W'(3);
   localparam logic [CMP_W-1:0] W_MAX    = CMP_W'(MAX_WIDTH);
   localparam logic [CMP_W-1:0] COL_FIRST = CMP_W'(2);
   localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(2);
   localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(MAX_ROWS - 1);
   localparam logic [CH_W-1:0]  CH_MAX    = '1;

   // filter one channel: left column plus center minus right column, clamped
   function automatic logic [CH_W-1:0] filt(
      input logic [CH_W-1:0] l0, l1, l2, ctr, r0, r1, r2
   );
      logic signed [SUM_W-1:0] s;
      s = $signed(SUM_W'(l0)) + $signed(SUM_W'(l1)) + $signed(SUM_W'(l2))
        + $signed(SUM_W'(ctr)) - $signed(SUM_W'(r0)) - $signed(SUM_W'(r1))
        - $signed(SUM_W'(r2));
      if (s < 0) begin
         return '0;
      end else if (s > $signed(SUM_W'(CH_MAX))) begin
         return CH_MAX;
      end else begin
         return s[CH_W-1:0];
      end
   endfunction

   // configuration register
   logic [c3rgb_pkg::CFG_W-1:0] row_width_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= c3rgb_pkg::ROW_WIDTH_RST;
      end else if (csr_valid && csr_ready) begin
         row_width_ff <= csr_row_width;
      end
   end

   // stage 0: position counters, result test, line store read
   logic                 accept;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [CMP_W-1:0]     width_raw, width_eff, col_ext, col_next;
   logic                 has_result;
   logic [COL_W-1:0]     col_m1;
   logic [ROW_W-1:0]     row_m1;
   logic [PIX_W-1:0]     req_pixel;

   assign accept    = req_valid && !req_stall;
   assign req_pixel = {req_pixel_red, req_pixel_green, req_pixel_blue};
   assign width_raw = CMP_W'(row_width_ff);
   assign width_eff = (width_raw < W_MIN) ? W_MIN :
                      (width_raw > W_MAX) ? W_MAX : width_raw;
   assign col_ext   = CMP_W'(col_ff);
   assign col_next  = col_ext + CMP_W'(1);
   assign has_result = (row_ff >= ROW_FIRST) && (col_ext >= COL_FIRST)
                     && (col_ext < width_eff);
   assign col_m1    = col_ff - COL_W'(1);
   assign row_m1    = row_ff - ROW_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (req_last_pixel) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= width_eff) begin
            col_in = '0;
            row_in = (row_ff == ROW_LAST) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1 registers
   logic                              s1_valid_ff, s1_res_ff;
   logic [COL_W-1:0]                  s1_idx_ff;
   logic [PIX_W-1:0]                  s1_px_ff;
   logic [c3rgb_pkg::ROW_OUT_W-1:0]   s1_row_ff;
   logic [c3rgb_pkg::COL_OUT_W-1:0]   s1_col_ff;
   logic                              fwd_ff, fwd_in;
   logic [PIX_W-1:0]                  fwd_up_ff, fwd_mid_ff;
   logic [PIX_W-1:0]                  up_rd_ff, mid_rd_ff;
   logic [PIX_W-1:0]                  up_eff, mid_eff;

   // the word still writing back at this index hands its values over
   assign fwd_in  = s1_valid_ff && (s1_idx_ff == col_ff);
   assign up_eff  = fwd_ff ? fwd_up_ff  : up_rd_ff;
   assign mid_eff = fwd_ff ? fwd_mid_ff : mid_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_res_ff   <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_res_ff   <= accept && has_result;
         fwd_ff      <= accept && fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff  <= col_ff;
         s1_px_ff   <= req_pixel;
         s1_row_ff  <= c3rgb_pkg::ROW_OUT_W'(row_m1);
         s1_col_ff  <= c3rgb_pkg::COL_OUT_W'(col_m1);
         fwd_up_ff  <= mid_eff;
         fwd_mid_ff <= s1_px_ff;
      end
   end

   // line stores: read at the incoming column, written back from the stage 1 registers in the next cycle
   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff  <= upper_mem[col_ff];
         mid_rd_ff <= middle_mem[col_ff];
      end
      if (s1_valid_ff) begin
         upper_mem[s1_idx_ff]  <= mid_eff;
         middle_mem[s1_idx_ff] <= s1_px_ff;
      end
   end

   // window: center column and right column, top to bottom
   logic [PIX_W-1:0] win_ctr_ff [3];
   logic [PIX_W-1:0] win_rgt_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            win_ctr_ff[r] <= '0;
            win_rgt_ff[r] <= '0;
         end
      end else if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ctr_ff[r] <= win_rgt_ff[r];
         end
         win_rgt_ff[0] <= up_eff;
         win_rgt_ff[1] <= mid_eff;
         win_rgt_ff[2] <= s1_px_ff;
      end
   end

   // filter on the shifted window: old center column becomes the left one
   logic [CH_W-1:0]         filt_ch [3];
   c3rgb_pkg::rsp_word_type push_word;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         filt_ch[k] = filt(win_ctr_ff[0][CH_W*k +: CH_W],
                           win_ctr_ff[1][CH_W*k +: CH_W],
                           win_ctr_ff[2][CH_W*k +: CH_W],
                           win_rgt_ff[1][CH_W*k +: CH_W],
                           up_eff[CH_W*k +: CH_W],
                           mid_eff[CH_W*k +: CH_W],
                           s1_px_ff[CH_W*k +: CH_W]);
      end
      push_word.blue   = filt_ch[0];
      push_word.green  = filt_ch[1];
      push_word.red    = filt_ch[2];
      push_word.row    = s1_row_ff;
      push_word.column = s1_col_ff;
   end

   // output queue and input back-pressure
   c3rgb_pkg::rsp_word_type             q_word;
   logic [c3rgb_pkg::OUTQ_CNT_W-1:0]    q_count;
   logic [LOAD_W-1:0]                   q_load;

   c3rgb_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_res_ff),
      .push_word (push_word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (q_word),
      .count     (q_count)
   );

   assign q_load    = LOAD_W'(q_count) + LOAD_W'(s1_res_ff);
   assign req_stall = (q_load >= LOAD_W'(c3rgb_pkg::OUTQ_DEPTH));

   assign rsp_out_blue   = q_word.blue;
   assign rsp_out_green  = q_word.green;
   assign rsp_out_red    = q_word.red;
   assign rsp_out_row    = q_word.row;
   assign rsp_out_column = q_word.column;

endmodule

### dv/conv3x3_rgb_clamped_core_tb.sv
module conv3x3_rgb_clamped_core_tb;

   localparam int CH_MAX         = 255;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 5000;

   // filter mirror: line stores, window, counters, and the queue of words still due
   class conv_scoreboard;
      logic [c3rgb_pkg::PIX_W-1:0] upper_line [c3rgb_pkg::MAX_WIDTH_DEF];
      logic [c3rgb_pkg::PIX_W-1:0] middle_line [c3rgb_pkg::MAX_WIDTH_DEF];
      logic [c3rgb_pkg::PIX_W-1:0] win_cells [9];   // row*3+col, row 0 top, col 0 left
      int unsigned                 col_pos;
      int unsigned                 row_pos;
      logic [c3rgb_pkg::CFG_W-1:0] width_reg;
      c3rgb_pkg::rsp_word_type     due_words [$];
      int                          mismatches;
      int                          words_seen;
      int                          pixels_seen;

      function new();
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         foreach (win_cells[i]) win_cells[i] = '0;
         col_pos     = 0;
         row_pos     = 0;
         width_reg   = c3rgb_pkg::ROW_WIDTH_RST;
         mismatches  = 0;
         words_seen  = 0;
         pixels_seen = 0;
      endfunction

      function void set_width(logic [c3rgb_pkg::CFG_W-1:0] v);
         width_reg = v;
      endfunction

      // register value clamped into the legal row length
      function int unsigned used_width();
         int unsigned w;
         w = 32'(width_reg);
         if (w < 3) w = 3;
         if (w > c3rgb_pkg::MAX_WIDTH_DEF) w = c3rgb_pkg::MAX_WIDTH_DEF;
         return w;
      endfunction

      function int chan_of(logic [c3rgb_pkg::PIX_W-1:0] px, int ch);
         return int'(px[ch*c3rgb_pkg::CH_W +: c3rgb_pkg::CH_W]);
      endfunction

      // left column plus center minus right column, clamped
      function logic [c3rgb_pkg::CH_W-1:0] filter_chan(int ch);
         int s;
         s = chan_of(win_cells[0], ch) + chan_of(win_cells[3], ch)
           + chan_of(win_cells[4], ch) + chan_of(win_cells[6], ch)
           - chan_of(win_cells[2], ch) - chan_of(win_cells[5], ch)
           - chan_of(win_cells[8], ch);
         if (s > CH_MAX) s = CH_MAX;
         if (s < 0) s = 0;
         return c3rgb_pkg::CH_W'(s);
      endfunction

      // advance the window by one accepted pixel, queue a word for interior centers
      function void note_pixel(logic [c3rgb_pkg::CH_W-1:0] b,
                               logic [c3rgb_pkg::CH_W-1:0] g,
                               logic [c3rgb_pkg::CH_W-1:0] rd, logic last);
         logic [c3rgb_pkg::PIX_W-1:0] px;
         int unsigned                 w;
         int unsigned                 c;
         int unsigned                 idx;
         c3rgb_pkg::rsp_word_type     word;
         px  = {rd, g, b};
         w   = used_width();
         c   = col_pos;
         idx = c % c3rgb_pkg::MAX_WIDTH_DEF;
         pixels_seen++;
         for (int k = 0; k < 3; k++) begin
            win_cells[k*3]     = win_cells[k*3 + 1];
            win_cells[k*3 + 1] = win_cells[k*3 + 2];
         end
         win_cells[2]     = upper_line[idx];
         win_cells[5]     = middle_line[idx];
         win_cells[8]     = px;
         upper_line[idx]  = middle_line[idx];
         middle_line[idx] = px;
         if (row_pos >= 2 && c >= 2 && c <= w - 1) begin
            word.blue   = filter_chan(0);
            word.green  = filter_chan(1);
            word.red    = filter_chan(2);
            word.row    = c3rgb_pkg::ROW_OUT_W'(row_pos - 1);
            word.column = c3rgb_pkg::COL_OUT_W'(c - 1);
            due_words.push_back(word);
         end
         // frame end clears both counters, row end wraps the column
         if (last) begin
            col_pos = 0;
            row_pos = 0;
         end else begin
            c++;
            if (c >= w) begin
               col_pos = 0;
               row_pos++;
               if (row_pos >= c3rgb_pkg::MAX_ROWS_DEF) row_pos = 0;
            end else begin
               col_pos = c;
            end
         end
      endfunction

      task report(string msg);
         $display("%0t MISMATCH %s", $time, msg);
         mismatches++;
      endtask

      task field_check(string name, logic [15:0] got, logic [15:0] want,
                       c3rgb_pkg::rsp_word_type at);
         if (got !== want)
            report($sformatf("%s got %0d want %0d (center row %0d col %0d)",
                             name, got, want, at.row, at.column));
      endtask

      task check_word(c3rgb_pkg::rsp_word_type got);
         c3rgb_pkg::rsp_word_type want;
         words_seen++;
         if (due_words.size() == 0) begin
            report($sformatf("word with none due: row %0d col %0d", got.row, got.column));
         end else begin
            want = due_words.pop_front();
            field_check("blue", 16'(got.blue), 16'(want.blue), want);
            field_check("green", 16'(got.green), 16'(want.green), want);
            field_check("red", 16'(got.red), 16'(want.red), want);
            field_check("row", 16'(got.row), 16'(want.row), want);
            field_check("column", 16'(got.column), 16'(want.column), want);
         end
      endtask

      task check_drained();
         if (due_words.size() != 0)
            report($sformatf("%0d words never arrived", due_words.size()));
      endtask
   endclass

   logic                                clock;
   logic                                reset           = 1'b1;
   logic                                req_valid       = 1'b0;
   logic                                req_stall;
   logic [c3rgb_pkg::CH_W-1:0]          req_pixel_blue  = '0;
   logic [c3rgb_pkg::CH_W-1:0]          req_pixel_green = '0;
   logic [c3rgb_pkg::CH_W-1:0]          req_pixel_red   = '0;
   logic                                req_last_pixel  = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall       = 1'b0;
   logic [c3rgb_pkg::CH_W-1:0]          rsp_out_blue;
   logic [c3rgb_pkg::CH_W-1:0]          rsp_out_green;
   logic [c3rgb_pkg::CH_W-1:0]          rsp_out_red;
   logic [c3rgb_pkg::ROW_OUT_W-1:0]     rsp_out_row;
   logic [c3rgb_pkg::COL_OUT_W-1:0]     rsp_out_column;
   logic                                csr_valid       = 1'b0;
   logic                                csr_ready;
   logic [c3rgb_pkg::CFG_W-1:0]         csr_row_width   = '0;

   conv_scoreboard          sb;
   c3rgb_pkg::rsp_word_type seen_word;
   int                      send_idle_pct = 9;
   int                      rsp_stall_pct = 62;
   int                      idle_cycles   = 0;

   conv3x3_rgb_clamped_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_blue (req_pixel_blue),
      .req_pixel_green(req_pixel_green),
      .req_pixel_red  (req_pixel_red),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_column (rsp_out_column),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_row_width  (csr_row_width)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: check accepted words, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_word.blue   = rsp_out_blue;
         seen_word.green  = rsp_out_green;
         seen_word.red    = rsp_out_red;
         seen_word.row    = rsp_out_row;
         seen_word.column = rsp_out_column;
         sb.check_word(seen_word);
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // present one pixel word, with random idle cycles ahead of it
   task automatic send_pixel(input logic [c3rgb_pkg::CH_W-1:0] b,
                             input logic [c3rgb_pkg::CH_W-1:0] g,
                             input logic [c3rgb_pkg::CH_W-1:0] rd, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_blue  <= b;
      req_pixel_green <= g;
      req_pixel_red   <= rd;
      req_last_pixel  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(b, g, rd, last);
   endtask

   // random frame of count pixels, last flag on the final one only
   task automatic send_frame(input int count);
      for (int i = 0; i < count; i++)
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == count - 1);
   endtask

   // hold the sender until every due word has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.due_words.size() != 0);
   endtask

   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [c3rgb_pkg::CFG_W-1:0] v);
      settle();
      csr_valid     <= 1'b1;
      csr_row_width <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_width(v);
   endtask

   // frames of random width and length, some cut short by an early last flag
   task automatic random_frames(input int items, input bit pause_once);
      int sent;
      int w;
      int eff;
      int count;
      int pause_at;
      bit paused;
      sent     = 0;
      paused   = 1'b0;
      pause_at = pause_once ? $urandom_range(20, items / 2) : -1;
      while (sent < items) begin
         case ($urandom_range(9))
            0: begin
               w = $urandom_range(4095);
            end
            1: begin
               w = $urandom_range(2);
            end
            default: begin
               w = $urandom_range(3, 12);
            end
         endcase
         write_width(c3rgb_pkg::CFG_W'(w));
         eff = sb.used_width();
         if (eff > 40)
            count = $urandom_range(1, 30);
         else
            count = eff * $urandom_range(3, 6) + $urandom_range(0, eff - 1);
         for (int i = 0; i < count; i++) begin
            if (!paused && sent == pause_at) begin
               drain();
               paused = 1'b1;
            end
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                       (i == count - 1) || ($urandom_range(99) < 2));
            sent++;
         end
      end
   endtask

   initial begin
      int kc;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset width: a short frame that never reaches an interior center
      send_frame(20);

      // width 3, both clamps in one window, then a flat white frame
      write_width(c3rgb_pkg::CFG_W'(3));
      for (int k = 0; k < 9; k++) begin
         kc = k % 3;
         send_pixel(kc < 2 ? 8'hFF : 8'h00, kc < 2 ? 8'h00 : 8'hFF, 8'h80, k == 8);
      end
      for (int k = 0; k < 9; k++)
         send_pixel(8'hFF, 8'hFF, 8'hFF, k == 8);

      // register zero acts as width 3
      write_width('0);
      for (int k = 0; k < 9; k++)
         send_pixel(8'h00, 8'h00, 8'h00, k == 8);

      // all ones acts as the maximum width; too short for any result
      write_width('1);
      send_frame(20);

      // width cut mid-frame: column past the new width ends the row
      write_width(c3rgb_pkg::CFG_W'(8));
      for (int k = 0; k < 3 * 8 + 6; k++)
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      write_width(c3rgb_pkg::CFG_W'(4));
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      send_frame(8);

      random_frames(220, 1'b0);

      // sender busy, receiver mostly ready
      send_idle_pct = 62;
      rsp_stall_pct = 9;
      random_frames(220, 1'b1);

      // full rate both ways
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_frames(220, 1'b0);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.check_drained();

      $display("Checked %0d result words from %0d pixels at widths 3 to 2048,",
               sb.words_seen, sb.pixels_seen);
      $display("with clamped settings, a mid-frame width cut, early frame ends and stalls.");
      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
